// ===== rtl/cfrpa_pkg.sv =====
// Shared types and constants of the checked frame receiver and page assembler.
// Depends on nothing; every rtl file refers to it by scoped names.
`default_nettype none
package cfrpa_pkg;

   localparam int CHUNK_BYTES_DEF     = 128;
   localparam int CHUNKS_PER_PAGE_DEF = 16;
   localparam int FRAME_MAX_DEF       = 135;
   localparam int QUEUE_DEPTH         = 2;
   localparam int ACK_LEN             = 5;

   localparam logic [7:0]  HDR_BYTE      = 8'h01;
   localparam logic [15:0] TIMEOUT_RESET = 16'd200;
   localparam logic [15:0] IDLE_MAX      = 16'hFFFF;

   typedef enum logic [1:0] {
      ACT_BYTE     = 2'd0,
      ACT_TICK     = 2'd1,
      ACT_CONSUMED = 2'd2
   } act_type;

   typedef enum logic [1:0] {
      KIND_ACK   = 2'd0,
      KIND_WORD  = 2'd1,
      KIND_READY = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_ACK,
      BK_FETCH,
      BK_WORD,
      BK_READY
   } bk_state_type;

   typedef struct packed {
      logic [7:0] idx;
      logic [7:0] len;
      logic       append;
      logic       ready;
      logic       fin;
      logic [8:0] base;
   } job_type;

   typedef struct packed {
      logic       en;
      logic [7:0] offset;
      logic [7:0] data;
   } mem_wr_type;

endpackage
`default_nettype wire

// ===== rtl/checked_frame_receiver_page_assembler_core.sv =====
// Channel  Dir  Handshake              Payload
// req      in   req_tvalid/req_tready  tdata rx_byte, tuser action
// rsp      out  rsp_tvalid/rsp_tready  tdata data, word_index; tuser kind, final; tlast
// csr      in   csr_valid/csr_ready    csr_data timeout_ticks
//
// For a good frame the back end takes the job, emits the five ack bytes, then does a
// fetch and an emit per payload word, ceil(len / 4) words, and emits page ready last
// when the job marks the page ready. While a payload job is outstanding, or the job
// queue is full, requests stall. Reset is synchronous; no clearing pass is needed.
// Depends on cfrpa_pkg, cfrpa_front, cfrpa_queue and cfrpa_back.
`default_nettype none
module checked_frame_receiver_page_assembler_core #(
   parameter int CHUNK_BYTES     = cfrpa_pkg::CHUNK_BYTES_DEF,
   parameter int CHUNKS_PER_PAGE = cfrpa_pkg::CHUNKS_PER_PAGE_DEF,
   parameter int FRAME_MAX       = cfrpa_pkg::FRAME_MAX_DEF
) (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   input  wire  [7:0]   req_tdata,   // rx_byte[7:0]
   input  wire  [1:0]   req_tuser,   // action[1:0]
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   output logic [47:0]  rsp_tdata,   // data[31:0], word_index[40:32], zero fill
   output logic [2:0]   rsp_tuser,   // kind[1:0], final_frame[2]
   output logic         rsp_tlast,
   input  wire          csr_valid,
   output logic         csr_ready,
   input  wire  [15:0]  csr_data
);

   logic                  item_accept;
   logic                  lock;
   logic                  push;
   logic                  q_full;
   logic                  q_valid;
   logic                  pop;
   logic                  bk_done;
   cfrpa_pkg::job_type    push_job;
   cfrpa_pkg::job_type    pop_job;
   cfrpa_pkg::mem_wr_type wr;

   assign req_tready  = !q_full && !lock;
   assign item_accept = req_tvalid && req_tready;
   assign csr_ready   = 1'b1;

   cfrpa_front #(
      .CHUNK_BYTES     (CHUNK_BYTES),
      .CHUNKS_PER_PAGE (CHUNKS_PER_PAGE),
      .FRAME_MAX       (FRAME_MAX)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_data    (csr_data),
      .item_accept (item_accept),
      .action      (req_tuser),
      .rx_byte     (req_tdata),
      .bk_done     (bk_done),
      .lock        (lock),
      .push        (push),
      .job         (push_job),
      .wr          (wr)
   );

   cfrpa_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (q_full),
      .pop      (pop),
      .valid    (q_valid),
      .pop_job  (pop_job)
   );

   cfrpa_back #(
      .CHUNK_BYTES (CHUNK_BYTES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .wr         (wr),
      .job_valid  (q_valid),
      .job        (pop_job),
      .pop        (pop),
      .done       (bk_done),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef SYNTHESIS
   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_full)
      else $error("job pushed into a full queue");

   a_done_locked: assert property (@(posedge clock) disable iff (reset)
      bk_done |-> lock)
      else $error("payload walk finished without an outstanding lock");

   a_ready_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[1:0] == cfrpa_pkg::KIND_READY) |-> rsp_tlast)
      else $error("page ready not marked last");
`endif

endmodule
`default_nettype wire

// ===== rtl/cfrpa_front.sv =====
// Front end: frame parser, checksum, timeout and page bookkeeping.
// Issues jobs to the queue and payload byte writes to the back end; uses cfrpa_pkg.
`default_nettype none
module cfrpa_front #(
   parameter int CHUNK_BYTES     = cfrpa_pkg::CHUNK_BYTES_DEF,
   parameter int CHUNKS_PER_PAGE = cfrpa_pkg::CHUNKS_PER_PAGE_DEF,
   parameter int FRAME_MAX       = cfrpa_pkg::FRAME_MAX_DEF
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     csr_valid,
   input  wire  [15:0]             csr_data,
   input  wire                     item_accept,
   input  wire  [1:0]              action,
   input  wire  [7:0]              rx_byte,
   input  wire                     bk_done,
   output logic                    lock,
   output logic                    push,
   output cfrpa_pkg::job_type      job,
   output cfrpa_pkg::mem_wr_type   wr
);

   localparam int WPC = (CHUNK_BYTES + 3) / 4;
   localparam int CW  = $clog2(CHUNKS_PER_PAGE + 1);

   logic [7:0]    count_ff, count_in;
   logic [7:0]    sum_ff, sum_in;
   logic [7:0]    idx_ff, idx_in;
   logic [7:0]    len_ff, len_in;
   logic [7:0]    last_index_ff, last_index_in;
   logic          seen_ff, seen_in;
   logic [CW-1:0] chunk_ff, chunk_in;
   logic          busy_ff, busy_in;
   logic [15:0]   idle_ff, idle_in;
   logic [15:0]   timeout_ff, timeout_in;
   logic          lock_ff, lock_in;

   logic [7:0]    pos;
   logic [CW-1:0] chunk_next;
   logic [15:0]   idle_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         last_index_ff <= '0;
         seen_ff       <= 1'b0;
         chunk_ff      <= '0;
         busy_ff       <= 1'b0;
         idle_ff       <= '0;
         timeout_ff    <= cfrpa_pkg::TIMEOUT_RESET;
         lock_ff       <= 1'b0;
      end else begin
         count_ff      <= count_in;
         last_index_ff <= last_index_in;
         seen_ff       <= seen_in;
         chunk_ff      <= chunk_in;
         busy_ff       <= busy_in;
         idle_ff       <= idle_in;
         timeout_ff    <= timeout_in;
         lock_ff       <= lock_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
      idx_ff <= idx_in;
      len_ff <= len_in;
   end

   always_comb begin
      count_in      = count_ff;
      sum_in        = sum_ff;
      idx_in        = idx_ff;
      len_in        = len_ff;
      last_index_in = last_index_ff;
      seen_in       = seen_ff;
      chunk_in      = chunk_ff;
      busy_in       = busy_ff;
      idle_in       = idle_ff;
      timeout_in    = timeout_ff;
      push          = 1'b0;
      job           = '0;
      wr            = '0;
      pos           = '0;
      chunk_next    = chunk_ff + 1'b1;
      idle_next     = (idle_ff < cfrpa_pkg::IDLE_MAX) ? idle_ff + 16'd1 : idle_ff;

      if (csr_valid) begin
         timeout_in = csr_data;
      end

      if (item_accept) begin
         unique case (action)
            cfrpa_pkg::ACT_BYTE: begin
               idle_in  = '0;
               pos      = (count_ff >= 8'(FRAME_MAX)) ? 8'd0 : count_ff;
               count_in = pos + 8'd1;
               sum_in   = (pos == 8'd0) ? rx_byte : sum_ff + rx_byte;
               if (pos >= 8'd4 && pos < 8'(CHUNK_BYTES + 4)) begin
                  wr.en     = 1'b1;
                  wr.offset = pos - 8'd4;
                  wr.data   = rx_byte;
               end
               if (pos == 8'd0 || pos == 8'd1) begin
                  if (rx_byte != cfrpa_pkg::HDR_BYTE) begin
                     count_in = '0;
                  end
               end else if (pos == 8'd2) begin
                  idx_in = rx_byte;
               end else if (pos == 8'd3) begin
                  len_in = rx_byte;
               end else if (len_ff <= 8'(CHUNK_BYTES) &&
                            ({1'b0, pos} + 9'd1) == ({1'b0, len_ff} + 9'd5)) begin
                  count_in = '0;
                  if (8'(8'd0 - sum_ff) == rx_byte && !busy_ff) begin
                     push     = 1'b1;
                     job.idx  = idx_ff;
                     job.len  = len_ff;
                     seen_in  = 1'b1;
                     if (!seen_ff || idx_ff != last_index_ff) begin
                        last_index_in = idx_ff;
                        job.append    = 1'b1;
                        job.base      = 9'(chunk_ff * WPC);
                        chunk_in      = chunk_next;
                        if (chunk_next >= CW'(CHUNKS_PER_PAGE)) begin
                           chunk_in  = '0;
                           busy_in   = 1'b1;
                           job.ready = 1'b1;
                        end
                        if (len_ff == 8'd0) begin
                           chunk_in  = '0;
                           busy_in   = 1'b1;
                           job.ready = 1'b1;
                           job.fin   = 1'b1;
                        end
                     end
                  end
               end
               if (timeout_ff == 16'd0) begin
                  count_in = '0;
               end
            end
            cfrpa_pkg::ACT_TICK: begin
               idle_in = idle_next;
               if (idle_next >= timeout_ff) begin
                  count_in = '0;
               end
            end
            cfrpa_pkg::ACT_CONSUMED: begin
               busy_in = 1'b0;
            end
            default: begin
            end
         endcase
      end

      lock_in = lock_ff;
      if (push && job.append && job.len != 8'd0) begin
         lock_in = 1'b1;
      end else if (bk_done) begin
         lock_in = 1'b0;
      end
   end

   assign lock = lock_ff;

endmodule
`default_nettype wire

// ===== rtl/cfrpa_queue.sv =====
// Short job queue between the front end and the back end.
// Holds cfrpa_pkg::job_type entries; depth from cfrpa_pkg::QUEUE_DEPTH.
`default_nettype none
module cfrpa_queue (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  push,
   input  cfrpa_pkg::job_type   push_job,
   output logic                 full,
   input  wire                  pop,
   output logic                 valid,
   output cfrpa_pkg::job_type   pop_job
);

   localparam int DEPTH = cfrpa_pkg::QUEUE_DEPTH;
   localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNW   = $clog2(DEPTH + 1);

   cfrpa_pkg::job_type entries_ff [DEPTH];
   logic [PW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNW-1:0] count_ff, count_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   assign full    = (count_ff == CNW'(DEPTH));
   assign valid   = (count_ff != '0);
   assign pop_job = entries_ff[rd_ptr_ff];

endmodule
`default_nettype wire

// ===== rtl/cfrpa_back.sv =====
// Back end: payload word memory and result sequencer with output register.
// Emits acknowledge bytes, payload words and page ready; uses cfrpa_pkg.
`default_nettype none
module cfrpa_back #(
   parameter int CHUNK_BYTES = cfrpa_pkg::CHUNK_BYTES_DEF
) (
   input  wire                     clock,
   input  wire                     reset,
   input  cfrpa_pkg::mem_wr_type   wr,
   input  wire                     job_valid,
   input  cfrpa_pkg::job_type      job,
   output logic                    pop,
   output logic                    done,
   output logic                    rsp_tvalid,
   input  wire                     rsp_tready,
   output logic [47:0]             rsp_tdata,   // data[31:0], word_index[40:32], zero fill
   output logic [2:0]              rsp_tuser,   // kind[1:0], final_frame[2]
   output logic                    rsp_tlast
);

   localparam int WPC = (CHUNK_BYTES + 3) / 4;
   localparam int AW  = (WPC > 1) ? $clog2(WPC) : 1;

   logic [31:0] mem_ff [WPC];
   logic [31:0] rd_data_ff;

   cfrpa_pkg::bk_state_type state_ff, state_in;
   cfrpa_pkg::job_type      job_ff, job_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic [5:0]  k_ff, k_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  kind_ff, kind_in;
   logic [31:0] data_ff, data_in;
   logic [8:0]  widx_ff, widx_in;
   logic        fin_ff, fin_in;
   logic        last_ff, last_in;

   logic        slot_free;
   logic [8:0]  nwords;
   logic        last_word;
   logic [31:0] word;
   logic [7:0]  ack_byte;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.offset[AW+1:2]][wr.offset[1:0]*8 +: 8] <= wr.data;
      end
      rd_data_ff <= mem_ff[k_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cfrpa_pkg::BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff  <= job_in;
      cnt_ff  <= cnt_in;
      k_ff    <= k_in;
      kind_ff <= kind_in;
      data_ff <= data_in;
      widx_ff <= widx_in;
      fin_ff  <= fin_in;
      last_ff <= last_in;
   end

   always_comb begin
      nwords    = ({1'b0, job_ff.len} + 9'd3) >> 2;
      last_word = ({3'b0, k_ff} + 9'd1) == nwords;
      for (int j = 0; j < 4; j++) begin
         word[j*8 +: 8] = ({k_ff, 2'(j)} < job_ff.len) ? rd_data_ff[j*8 +: 8] : 8'd0;
      end
      unique case (cnt_ff)
         3'd0, 3'd1: ack_byte = cfrpa_pkg::HDR_BYTE;
         3'd2:       ack_byte = job_ff.idx;
         3'd3:       ack_byte = 8'd0;
         default:    ack_byte = 8'(9'h100 - {1'b0, cfrpa_pkg::HDR_BYTE}
                                   - {1'b0, cfrpa_pkg::HDR_BYTE} - {1'b0, job_ff.idx});
      endcase
   end

   always_comb begin
      slot_free    = !rsp_valid_ff || rsp_tready;
      state_in     = state_ff;
      job_in       = job_ff;
      cnt_in       = cnt_ff;
      k_in         = k_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      kind_in      = kind_ff;
      data_in      = data_ff;
      widx_in      = widx_ff;
      fin_in       = fin_ff;
      last_in      = last_ff;
      pop          = 1'b0;
      done         = 1'b0;

      unique case (state_ff)
         cfrpa_pkg::BK_IDLE: begin
            if (job_valid) begin
               pop      = 1'b1;
               job_in   = job;
               cnt_in   = '0;
               k_in     = '0;
               state_in = cfrpa_pkg::BK_ACK;
            end
         end
         cfrpa_pkg::BK_ACK: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               kind_in      = cfrpa_pkg::KIND_ACK;
               data_in      = {24'd0, ack_byte};
               widx_in      = '0;
               fin_in       = 1'b0;
               last_in      = 1'b0;
               cnt_in       = cnt_ff + 3'd1;
               if (cnt_ff == 3'(cfrpa_pkg::ACK_LEN - 1)) begin
                  if (job_ff.append && job_ff.len != 8'd0) begin
                     state_in = cfrpa_pkg::BK_FETCH;
                  end else if (job_ff.ready) begin
                     state_in = cfrpa_pkg::BK_READY;
                  end else begin
                     last_in  = 1'b1;
                     state_in = cfrpa_pkg::BK_IDLE;
                  end
               end
            end
         end
         cfrpa_pkg::BK_FETCH: begin
            state_in = cfrpa_pkg::BK_WORD;
         end
         cfrpa_pkg::BK_WORD: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               kind_in      = cfrpa_pkg::KIND_WORD;
               data_in      = word;
               widx_in      = job_ff.base + {3'b0, k_ff};
               fin_in       = 1'b0;
               last_in      = 1'b0;
               if (last_word) begin
                  done = 1'b1;
                  if (job_ff.ready) begin
                     state_in = cfrpa_pkg::BK_READY;
                  end else begin
                     last_in  = 1'b1;
                     state_in = cfrpa_pkg::BK_IDLE;
                  end
               end else begin
                  k_in     = k_ff + 6'd1;
                  state_in = cfrpa_pkg::BK_FETCH;
               end
            end
         end
         cfrpa_pkg::BK_READY: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               kind_in      = cfrpa_pkg::KIND_READY;
               data_in      = '0;
               widx_in      = '0;
               fin_in       = job_ff.fin;
               last_in      = 1'b1;
               state_in     = cfrpa_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = cfrpa_pkg::BK_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, widx_ff, data_ff};
   assign rsp_tuser  = {fin_ff, kind_ff};
   assign rsp_tlast  = last_ff;

endmodule
`default_nettype wire
